[src/fpba_pkg.sv]
// ============================================================================
// fpba_pkg
// Shared types, codes and widths of the fit-policy block allocator.
// ============================================================================
package fpba_pkg;

    // Payload field widths
    localparam int FUNC_W     = 1;
    localparam int LOAD_IDX_W = 4;
    localparam int AMOUNT_W   = 16;
    localparam int CHOSEN_W   = 4;

    // Configuration port widths
    localparam int POLICY_W    = 2;
    localparam int BCOUNT_W    = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    // Parameter defaults
    localparam int BLOCKS_DEF     = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    // Configuration reset values
    localparam logic [POLICY_W-1:0] POLICY_RST = 2'd0;
    localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 5'd16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    // Placement rules
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted item, clear the search
        logic load_wr;   // write the load amount into the table
        logic rd_en;     // read one table entry for the search
        logic tbl_wr;    // write back the chosen entry when found
        logic out_load;  // move the result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } status_t;

endpackage

[src/fpba_if.sv]
// ============================================================================
// fpba_if
// Valid/ready channels for allocator requests and results.
// ============================================================================
interface fpba_item_if import fpba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic [LOAD_IDX_W-1:0] load_index;
    logic [AMOUNT_W-1:0]   amount;
    logic                  final_request;

    modport source (output valid, output func, output load_index, output amount,
                    output final_request, input ready);
    modport sink   (input valid, input func, input load_index, input amount,
                    input final_request, output ready);
endinterface

interface fpba_result_if import fpba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                granted;
    logic [CHOSEN_W-1:0] chosen_block;
    logic                final_result;

    modport source (output valid, output granted, output chosen_block,
                    output final_result, input ready);
    modport sink   (input valid, input granted, input chosen_block,
                    input final_result, output ready);
endinterface

[src/fpba_ctrl.sv]
// ============================================================================
// fpba_ctrl
// Sequencer of the allocator: configuration registers, request handshake
// and the table scan counter.
// ============================================================================
module fpba_ctrl import fpba_pkg::*; #(
    parameter int BLOCKS = BLOCKS_DEF,
    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic [FUNC_W-1:0]     item_func,
    output logic                  item_ready,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  status_t               status,
    output cmd_t                  cmd,
    output logic [IDX_W-1:0]      rd_addr,
    output logic [POLICY_W-1:0]   policy
);

    localparam int CNT_W = $clog2(BLOCKS + 1);
    localparam int LW    = (CNT_W > BCOUNT_W) ? CNT_W : BCOUNT_W;

    logic [POLICY_W-1:0] policy_reg;
    logic [BCOUNT_W-1:0] bcount_reg;
    state_t              state_reg, state_next;
    logic [LW-1:0]       cnt_reg, cnt_next;
    logic [LW-1:0]       limit;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_RST;
            bcount_reg <= BCOUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_POLICY:      policy_reg <= cfg_data[POLICY_W-1:0];
                CFG_BLOCK_COUNT: bcount_reg <= cfg_data[BCOUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Saturate the search length at the table depth
    assign limit = (LW'(bcount_reg) > LW'(BLOCKS)) ? LW'(BLOCKS) : LW'(bcount_reg);

    // Hold state and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    if (item_func == FUNC_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else if (limit == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == limit - LW'(1))
                    state_next = ST_DRAIN;
                else
                    cnt_next = cnt_reg + LW'(1);
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.tbl_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = cnt_reg[IDX_W-1:0];
    assign policy  = policy_reg;

    // Scan address never leaves the searched range
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg < limit))
        else $error("scan counter beyond search limit");

    // An accepted request closes the input until its result is queued
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("second request accepted while busy");

endmodule

[src/fpba_dp.sv]
// ============================================================================
// fpba_dp
// Datapath of the allocator: free-size table, fit comparison, pick tracking
// and the result register.
// ============================================================================
module fpba_dp import fpba_pkg::*; #(
    parameter int BLOCKS     = BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF,
    localparam int IDX_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FUNC_W-1:0]     item_func,
    input  logic [LOAD_IDX_W-1:0] item_load_index,
    input  logic [AMOUNT_W-1:0]   item_amount,
    input  logic                  item_final,
    input  cmd_t                  cmd,
    input  logic [IDX_W-1:0]      rd_addr,
    input  logic [POLICY_W-1:0]   policy,
    output status_t               status,
    fpba_result_if.source         result
);

    localparam int CMP_W = (SIZE_WIDTH > AMOUNT_W) ? SIZE_WIDTH : AMOUNT_W;

    logic [SIZE_WIDTH-1:0] mem [BLOCKS];
    logic [BLOCKS-1:0]     valid_reg;

    logic [FUNC_W-1:0]     func_reg;
    logic [LOAD_IDX_W-1:0] index_reg;
    logic [AMOUNT_W-1:0]   amount_reg;
    logic                  final_reg;

    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg;

    logic                  found_reg;
    logic [IDX_W-1:0]      pick_reg;
    logic [SIZE_WIDTH-1:0] pick_size_reg;

    logic                  out_valid_reg;
    logic                  granted_reg;
    logic [CHOSEN_W-1:0]   chosen_reg;
    logic                  final_out_reg;

    logic                  load_ok;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [SIZE_WIDTH-1:0] wr_data;
    logic                  fits;
    logic                  better;

    // Select the table write: a load, or the write-back of a grant
    assign load_ok = (32'(item_load_index) < BLOCKS);
    assign wr_en   = (cmd.load_wr && load_ok) || (cmd.tbl_wr && found_reg);
    assign wr_addr = cmd.load_wr ? IDX_W'(item_load_index) : pick_reg;
    assign wr_data = cmd.load_wr ? SIZE_WIDTH'(item_amount)
                                 : pick_size_reg - SIZE_WIDTH'(amount_reg);

    // Table storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr_en)
            valid_reg[wr_addr] <= 1'b1;
    end

    // Registered table read for the scan
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= cmd.rd_en;
    end

    // Latch the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= item_func;
            index_reg  <= item_load_index;
            amount_reg <= item_amount;
            final_reg  <= item_final;
        end
    end

    // Compare the returned entry against the request and the current pick
    assign fits = (CMP_W'(rd_data_reg) >= CMP_W'(amount_reg));
    always_comb
    begin
        case (policy)
            POL_BEST:  better = (rd_data_reg < pick_size_reg);
            POL_WORST: better = (rd_data_reg > pick_size_reg);
            default:   better = 1'b0;
        endcase
    end

    // Track the found flag; first fit keeps the lowest index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.capture)
            found_reg <= 1'b0;
        else if (rd_vld_reg && fits)
            found_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && fits && (!found_reg || better))
        begin
            pick_reg      <= rd_idx_reg;
            pick_size_reg <= rd_data_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            granted_reg   <= (func_reg == FUNC_REQUEST) && found_reg;
            final_out_reg <= final_reg;
            if (func_reg == FUNC_LOAD)
                chosen_reg <= CHOSEN_W'(index_reg);
            else if (found_reg)
                chosen_reg <= CHOSEN_W'(pick_reg);
            else
                chosen_reg <= '0;
        end
    end

    assign status.out_free     = !out_valid_reg || result.ready;
    assign result.valid        = out_valid_reg;
    assign result.granted      = granted_reg;
    assign result.chosen_block = chosen_reg;
    assign result.final_result = final_out_reg;

    // A held pick always fits the request
    a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && func_reg == FUNC_REQUEST)
            |-> (CMP_W'(pick_size_reg) >= CMP_W'(amount_reg)))
        else $error("picked entry smaller than request");

    // A result appears only when the controller queues one
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.out_load))
        else $error("result valid without a queued result");

endmodule

[src/fit_policy_block_allocator_core.sv]
// ============================================================================
// fit_policy_block_allocator_core
// Free-size table with first, best and worst fit placement.
// ============================================================================
// A load request is accepted in ST_IDLE and goes to ST_DONE, where its
// result is queued; the block then returns to ST_IDLE for the next request.
// An allocation request passes through ST_SCAN, which reads min(block_count,
// BLOCKS) entries, then ST_DRAIN for the last read, ST_WRITE for the
// write-back and ST_DONE to queue the result. The table is a single memory
// read one entry per cycle. A refused request with a zero block count is
// handled like a load. Requests are handled one at a time; the output
// register lets a new request be accepted while the previous result waits,
// and a result that is still waiting when the next one is ready stalls the
// block.
module fit_policy_block_allocator_core import fpba_pkg::*; #(
    parameter int BLOCKS     = BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fpba_item_if.sink             item,
    fpba_result_if.source         result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    cmd_t                cmd;
    status_t             status;
    logic [IDX_W-1:0]    rd_addr;
    logic [POLICY_W-1:0] policy;

    // Sequencer
    fpba_ctrl #(
        .BLOCKS (BLOCKS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_func  (item.func),
        .item_ready (item.ready),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .policy     (policy)
    );

    // Table and result datapath
    fpba_dp #(
        .BLOCKS     (BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_func       (item.func),
        .item_load_index (item.load_index),
        .item_amount     (item.amount),
        .item_final      (item.final_request),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .policy          (policy),
        .status          (status),
        .result          (result)
    );

endmodule

[dv/fit_policy_block_allocator_core_tb.sv]
// ============================================================================
// fit_policy_block_allocator_core_tb
// Self-checking bench for the fit-policy block allocator. Loads and
// allocation requests are sent over the request channel. An internal
// free-size table predicts each grant or refusal under first, best and worst
// fit. Results are checked in order against that prediction. Both sides of
// the handshake idle at random, and the policy and block count are changed
// between phases.
// ============================================================================
module fit_policy_block_allocator_core_tb;
    import fpba_pkg::*;

    localparam int BLOCKS      = BLOCKS_DEF;
    localparam int SETTLE      = BLOCKS + 8;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_ITEMS = 40;
    localparam int PHASES      = 11;

    // Code 3 is unassigned and falls back to first fit
    localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

    // Initial free sizes: extremes, alternating bits and some ties
    localparam logic [AMOUNT_W-1:0] SEED_SIZES [BLOCKS] = '{
        16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd300, 16'd120, 16'd900, 16'd40,
        16'd2500, 16'd300, 16'd75, 16'd4000, 16'd300, 16'd60, 16'd1800, 16'd4000
    };

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [LOAD_IDX_W-1:0] load_index;
        logic [AMOUNT_W-1:0]   amount;
        logic                  final_request;
    } alloc_req_t;

    typedef struct packed {
        logic                granted;
        logic [CHOSEN_W-1:0] chosen_block;
        logic                final_result;
    } alloc_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fpba_item_if   req_ch ();
    fpba_result_if res_ch ();

    fit_policy_block_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (req_ch),
        .result    (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Predicted allocator state
    logic [AMOUNT_W-1:0] free_sizes [BLOCKS];
    logic [POLICY_W-1:0] cur_policy;
    logic [BCOUNT_W-1:0] cur_count;

    alloc_req_t pending_reqs [$];
    alloc_res_t expected_grants [$];
    alloc_req_t sent_req;
    alloc_res_t next_grant;

    bit holding;
    bit quiet;
    int gap_left;
    int stall_left;
    int fail_cnt = 0;
    int idle_cycles;

    // Random idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one request to the predicted table and return its outcome
    function automatic alloc_res_t place_request(alloc_req_t rq);
        alloc_res_t res;
        int         span;
        int         pick;
        bit         found;
        res = '0;
        res.final_result = rq.final_request;
        pick = 0;
        found = 1'b0;
        if (rq.func == FUNC_LOAD)
        begin
            free_sizes[rq.load_index] = rq.amount;
            res.chosen_block = rq.load_index;
        end
        else
        begin
            span = (int'(cur_count) > BLOCKS) ? BLOCKS : int'(cur_count);
            for (int j = 0; j < span; j++)
            begin
                if (free_sizes[j] >= rq.amount)
                begin
                    if (!found)
                    begin
                        found = 1'b1;
                        pick = j;
                        if (cur_policy != POL_BEST && cur_policy != POL_WORST)
                            break;
                    end
                    else if (cur_policy == POL_BEST && free_sizes[j] < free_sizes[pick])
                        pick = j;
                    else if (cur_policy == POL_WORST && free_sizes[j] > free_sizes[pick])
                        pick = j;
                end
            end
            if (found)
            begin
                free_sizes[pick] = free_sizes[pick] - rq.amount;
                res.granted = 1'b1;
                res.chosen_block = CHOSEN_W'(pick);
            end
        end
        return res;
    endfunction

    function automatic void push_req(logic [FUNC_W-1:0] f, logic [LOAD_IDX_W-1:0] idx,
                                     logic [AMOUNT_W-1:0] amt, logic fin);
        pending_reqs.push_back(alloc_req_t'{f, idx, amt, fin});
    endfunction

    // Hold until every request is sent and every result is back
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || holding || expected_grants.size() != 0)
            @(posedge clk);
    endtask

    // Drain, let the block settle, then write both registers
    task automatic set_mode(input logic [POLICY_W-1:0] pol, input logic [BCOUNT_W-1:0] cnt);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_POLICY;
        cfg_data  <= CFG_DATA_W'(pol);
        @(posedge clk);
        cfg_index <= CFG_BLOCK_COUNT;
        cfg_data  <= CFG_DATA_W'(cnt);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_policy = pol;
        cur_count  = cnt;
    endtask

    // Request driver: predict on acceptance, then present the next request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.func          <= FUNC_LOAD;
            req_ch.load_index    <= '0;
            req_ch.amount        <= '0;
            req_ch.final_request <= 1'b0;
            holding = 1'b0;
            gap_left = 0;
            for (int i = 0; i < BLOCKS; i++)
                free_sizes[i] = '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_grants.push_back(place_request(sent_req));
                holding = 1'b0;
                gap_left = pick_gap();
            end
            if (!holding)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() != 0)
                begin
                    sent_req = pending_reqs.pop_front();
                    holding = 1'b1;
                    req_ch.func          <= sent_req.func;
                    req_ch.load_index    <= sent_req.load_index;
                    req_ch.amount        <= sent_req.amount;
                    req_ch.final_request <= sent_req.final_request;
                end
            end
            req_ch.valid <= holding;
        end
    end

    // Result monitor: check against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_cnt++;
                end
                else
                begin
                    next_grant = expected_grants.pop_front();
                    if (res_ch.granted !== next_grant.granted)
                    begin
                        $error("granted: expected %0d, got %0d",
                               next_grant.granted, res_ch.granted);
                        fail_cnt++;
                    end
                    if (res_ch.chosen_block !== next_grant.chosen_block)
                    begin
                        $error("chosen_block: expected %0d, got %0d",
                               next_grant.chosen_block, res_ch.chosen_block);
                        fail_cnt++;
                    end
                    if (res_ch.final_result !== next_grant.final_result)
                    begin
                        $error("final_result: expected %0d, got %0d",
                               next_grant.final_result, res_ch.final_result);
                        fail_cnt++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("fit_policy_block_allocator_core test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

    // Stimulus sequencer
    initial
    begin
        logic [POLICY_W-1:0] phase_pol [PHASES];
        logic [BCOUNT_W-1:0] phase_cnt [PHASES];
        alloc_req_t          rq;
        int                  sel;

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_POLICY;
        cfg_data = '0;
        quiet = 1'b0;
        cur_policy = POLICY_RST;
        cur_count = BCOUNT_RST;

        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: fill every entry, then exercise each rule and edge case
        for (int i = 0; i < BLOCKS; i++)
            push_req(FUNC_LOAD, LOAD_IDX_W'(i), SEED_SIZES[i], i[0]);
        push_req(FUNC_REQUEST, 4'd15, 16'd0, 1'b0);      // zero request fits anywhere
        push_req(FUNC_REQUEST, 4'd0, 16'hFFFF, 1'b1);    // largest request, exact fit
        push_req(FUNC_REQUEST, 4'd0, 16'hFFFF, 1'b0);    // nothing left that large
        push_req(FUNC_REQUEST, 4'd7, 16'd100, 1'b1);

        set_mode(POL_BEST, 5'd16);
        push_req(FUNC_REQUEST, 4'd0, 16'd300, 1'b0);     // three-way tie
        push_req(FUNC_REQUEST, 4'd0, 16'd50, 1'b1);

        set_mode(POL_WORST, 5'd16);
        push_req(FUNC_REQUEST, 4'd0, 16'd10, 1'b0);
        push_req(FUNC_REQUEST, 4'd0, 16'd4000, 1'b1);

        set_mode(POL_UNUSED, 5'd16);
        push_req(FUNC_REQUEST, 4'd0, 16'd1, 1'b0);

        set_mode(POL_FIRST, 5'd0);                       // empty search window
        push_req(FUNC_REQUEST, 4'd0, 16'd0, 1'b1);
        push_req(FUNC_LOAD, 4'd0, 16'd500, 1'b0);

        set_mode(POL_FIRST, 5'd31);                      // window wider than the table
        push_req(FUNC_REQUEST, 4'd0, 16'd5000, 1'b0);

        // Random phases over a spread of settings
        phase_pol = '{POL_BEST, POL_WORST, POL_UNUSED, POL_FIRST, POL_BEST, POL_WORST,
                      POL_FIRST, POL_BEST, 2'd0, 2'd0, 2'd0};
        phase_cnt = '{5'd16, 5'd31, 5'd5, 5'd1, 5'd0, 5'd16, 5'd12, 5'd3, 5'd0, 5'd0, 5'd0};
        for (int p = PHASES - 3; p < PHASES; p++)
        begin
            phase_pol[p] = POLICY_W'($urandom_range(0, 3));
            phase_cnt[p] = BCOUNT_W'($urandom_range(0, 31));
        end

        for (int p = 0; p < PHASES; p++)
        begin
            set_mode(phase_pol[p], phase_cnt[p]);
            quiet = (p % 4 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                rq.load_index = LOAD_IDX_W'($urandom_range(0, BLOCKS - 1));
                rq.final_request = ($urandom_range(0, 4) == 0);
                sel = $urandom_range(0, 9);
                if ($urandom_range(0, 99) < 35)
                begin
                    // Refill: extremes, a repeated size for ties, wide and narrow values
                    rq.func = FUNC_LOAD;
                    if (sel == 0)
                        rq.amount = '0;
                    else if (sel == 1)
                        rq.amount = '1;
                    else if (sel == 2)
                        rq.amount = 16'd1000;
                    else if (sel < 8)
                        rq.amount = AMOUNT_W'($urandom);
                    else
                        rq.amount = AMOUNT_W'($urandom_range(0, 8000));
                end
                else
                begin
                    // Allocate: mostly modest sizes so grants stay common
                    rq.func = FUNC_REQUEST;
                    if (sel == 0)
                        rq.amount = '0;
                    else if (sel == 1)
                        rq.amount = '1;
                    else if (sel == 2)
                        rq.amount = AMOUNT_W'($urandom);
                    else
                        rq.amount = AMOUNT_W'($urandom_range(1, 3000));
                end
                pending_reqs.push_back(rq);
            end
        end

        // Drain and let the pipeline empty before the verdict
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_cnt == 0)
            $display("fit_policy_block_allocator_core test passed");
        else
            $display("fit_policy_block_allocator_core test failed");
        $finish;
    end

endmodule
